/* rtl/bpu_pkg.sv */
// Shared constants, types and control codes for the bouncing particle updater.
`timescale 1ns / 1ps

package bpu_pkg;

    // Default build parameters
    localparam int BALL_COUNT_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;

    // Field widths of the channels
    localparam int BALL_W = 5;
    localparam int RAND_W = 16;
    localparam int POS_W  = 20;

    // State word widths
    localparam int STATE_W = 24;
    localparam int ENTRY_W = 4 * STATE_W;
    localparam int WIDE_W  = 48;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Launch constants, whole pixels per second
    localparam int LAUNCH_VX_SPAN = 600;
    localparam int LAUNCH_VX_OFF  = 300;
    localparam int LAUNCH_VY_BASE = 10;
    localparam int LAUNCH_VY_SPAN = 100;

    // Register reset values
    localparam logic [11:0] RST_FIELD_WIDTH  = 12'd640;
    localparam logic [11:0] RST_FIELD_HEIGHT = 12'd360;
    localparam logic [5:0]  RST_BALL_RADIUS  = 6'd8;
    localparam logic [11:0] RST_GRAVITY      = 12'd300;
    localparam logic [15:0] RST_TIME_STEP    = 16'd1114;
    localparam logic [15:0] RST_DRAG         = 16'd65202;
    localparam logic [15:0] RST_BOUNCE       = 16'd52429;

    typedef logic signed [STATE_W-1:0] t_s24;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_WIDTH  = 3'd0,
        CFG_FIELD_HEIGHT = 3'd1,
        CFG_BALL_RADIUS  = 3'd2,
        CFG_GRAVITY      = 3'd3,
        CFG_TIME_STEP    = 3'd4,
        CFG_DRAG         = 3'd5,
        CFG_BOUNCE       = 3'd6
    } t_cfg_idx;

    // Input command codes
    localparam logic CMD_STEP   = 1'b0;
    localparam logic CMD_LAUNCH = 1'b1;

    // Controller states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_L4,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_I1,
        ST_I2,
        ST_XL,
        ST_YL,
        ST_XH,
        ST_YH,
        ST_FIN,
        ST_WRITE
    } t_state;

    // Datapath operations, one per sequencer step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_TAKE,
        OP_LOAD,
        OP_L1,
        OP_L2,
        OP_L3,
        OP_L4,
        OP_D1,
        OP_D2,
        OP_D3,
        OP_I1,
        OP_I2,
        OP_XL,
        OP_YL,
        OP_XH,
        OP_YH,
        OP_FIN,
        OP_WRITE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   in_ready;
    } t_dp_cmd;

    typedef struct packed {
        logic ball_ok;     // ball on the input channel is inside the table
        logic relaunch;    // launch values are needed for the loaded ball
        logic launch_cmd;  // held item is a launch command
        logic clr_last;    // clearing pass is at its last entry
        logic out_full;    // result register holds a result not yet taken
    } t_dp_status;

endpackage

/* rtl/bpu_in_if.sv */
// Input item channel: valid/ready handshake with the ball command payload.
`timescale 1ns / 1ps

interface bpu_in_if;
    import bpu_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [BALL_W-1:0] ball;
    logic [RAND_W-1:0] rand_x;
    logic [RAND_W-1:0] rand_vx;
    logic [RAND_W-1:0] rand_vy;

    modport source (output valid, output command, output ball, output rand_x,
                    output rand_vx, output rand_vy, input ready);
    modport sink   (input valid, input command, input ball, input rand_x,
                    input rand_vx, input rand_vy, output ready);
endinterface

/* rtl/bpu_out_if.sv */
// Result channel: valid/ready handshake with the new ball position payload.
`timescale 1ns / 1ps

interface bpu_out_if;
    import bpu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BALL_W-1:0] ball_id;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              relaunched;

    modport source (output valid, output ball_id, output pos_x, output pos_y,
                    output relaunched, input ready);
    modport sink   (input valid, input ball_id, input pos_x, input pos_y,
                    input relaunched, output ready);
endinterface

/* rtl/bouncing_particle_update.sv */
// Top level of the bouncing particle updater: sequencer, datapath and checks.
`timescale 1ns / 1ps

// Keeps position and velocity of BALL_COUNT balls and answers every accepted
// item naming a ball inside the table with that ball's new position; an item
// naming a ball beyond the table is taken and dropped. One 25x17 multiplier is
// shared by all products, so an item runs as a chain of single-product steps:
// a launch runs the launch steps, a step the drag, integration and wall steps,
// and a step that relaunches a resting ball both; no new item is taken until
// the current one is written back. After reset the ball table is cleared one
// entry a cycle, during which no item is taken (configuration writes are). The
// result register lets the next item be taken while a result still waits;
// only the write-back stalls when an older result has not been taken.
module bouncing_particle_update #(
    parameter int BALL_COUNT    = bpu_pkg::BALL_COUNT_DEF,
    parameter int FRACTION_BITS = bpu_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bpu_in_if.sink                         i_in,
    bpu_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bpu_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    bpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bpu_datapath #(
        .BALL_COUNT    (BALL_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_in.command),
        .i_ball       (i_in.ball),
        .i_rand_x     (i_in.rand_x),
        .i_rand_vx    (i_in.rand_vx),
        .i_rand_vy    (i_in.rand_vy),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_ball_id    (o_out.ball_id),
        .o_pos_x      (o_out.pos_x),
        .o_pos_y      (o_out.pos_y),
        .o_relaunched (o_out.relaunched)
    );

    assign i_in.ready = cmd.in_ready;

    // Write-back never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_WRITE |-> !(o_out.valid && !o_out.ready))
        else $error("result register overwritten before transfer");

    // Every write-back presents a result in the next cycle
    a_write_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_WRITE |=> o_out.valid)
        else $error("write-back without a result");

    // A result only appears after a write-back
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.op == OP_WRITE))
        else $error("result appeared without write-back");

    // An item in the table blocks the input until its write-back
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && status.ball_ok |=> !i_in.ready)
        else $error("second item taken while one is in flight");

endmodule

/* rtl/bpu_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module bpu_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bpu_ctrl.sv */
// Sequencer for the ball update: clearing pass, launch, drag, integration, walls.
`timescale 1ns / 1ps

module bpu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bpu_pkg::t_dp_status i_status,
    output bpu_pkg::t_dp_cmd    o_cmd
);
    import bpu_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid && i_status.ball_ok) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = i_status.relaunch ? ST_L1 : ST_D1;
            end
            ST_L1:  n_state = ST_L2;
            ST_L2:  n_state = ST_L3;
            ST_L3:  n_state = ST_L4;
            ST_L4: begin
                n_state = i_status.launch_cmd ? ST_WRITE : ST_D1;
            end
            ST_D1:  n_state = ST_D2;
            ST_D2:  n_state = ST_D3;
            ST_D3:  n_state = ST_I1;
            ST_I1:  n_state = ST_I2;
            ST_I2:  n_state = ST_XL;
            ST_XL:  n_state = ST_YL;
            ST_YL:  n_state = ST_XH;
            ST_XH:  n_state = ST_YH;
            ST_YH:  n_state = ST_FIN;
            ST_FIN: n_state = ST_WRITE;
            ST_WRITE: begin
                if (!i_status.out_full) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.op = OP_CLEAR;
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_TAKE;
            end
            ST_LOAD: o_cmd.op = OP_LOAD;
            ST_L1:   o_cmd.op = OP_L1;
            ST_L2:   o_cmd.op = OP_L2;
            ST_L3:   o_cmd.op = OP_L3;
            ST_L4:   o_cmd.op = OP_L4;
            ST_D1:   o_cmd.op = OP_D1;
            ST_D2:   o_cmd.op = OP_D2;
            ST_D3:   o_cmd.op = OP_D3;
            ST_I1:   o_cmd.op = OP_I1;
            ST_I2:   o_cmd.op = OP_I2;
            ST_XL:   o_cmd.op = OP_XL;
            ST_YL:   o_cmd.op = OP_YL;
            ST_XH:   o_cmd.op = OP_XH;
            ST_YH:   o_cmd.op = OP_YH;
            ST_FIN:  o_cmd.op = OP_FIN;
            ST_WRITE: begin
                if (!i_status.out_full) o_cmd.op = OP_WRITE;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

/* rtl/bpu_datapath.sv */
// Datapath: configuration, ball table, shared multiplier and result register.
`timescale 1ns / 1ps

module bpu_datapath #(
    parameter int BALL_COUNT    = bpu_pkg::BALL_COUNT_DEF,
    parameter int FRACTION_BITS = bpu_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bpu_pkg::t_dp_cmd                i_cmd,
    output bpu_pkg::t_dp_status             o_status,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input payload
    input  logic                            i_command,
    input  logic [bpu_pkg::BALL_W-1:0]      i_ball,
    input  logic [bpu_pkg::RAND_W-1:0]      i_rand_x,
    input  logic [bpu_pkg::RAND_W-1:0]      i_rand_vx,
    input  logic [bpu_pkg::RAND_W-1:0]      i_rand_vy,
    // result register
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [bpu_pkg::BALL_W-1:0]      o_ball_id,
    output logic [bpu_pkg::POS_W-1:0]       o_pos_x,
    output logic [bpu_pkg::POS_W-1:0]       o_pos_y,
    output logic                            o_relaunched
);
    import bpu_pkg::*;

    localparam int IDX_W  = (BALL_COUNT > 1) ? $clog2(BALL_COUNT) : 1;
    localparam int MA_W   = 25;
    localparam int MB_W   = 17;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SH_W   = PROD_W + FRACTION_BITS;

    localparam t_wide ONE     = t_wide'(2 ** FRACTION_BITS);
    localparam t_wide VX_OFF  = t_wide'(LAUNCH_VX_OFF * (2 ** FRACTION_BITS));
    localparam t_wide VY_BASE = t_wide'(LAUNCH_VY_BASE * (2 ** FRACTION_BITS));
    localparam t_wide S24_MAX = t_wide'(8388607);
    localparam t_wide S24_MIN = -t_wide'(8388608);

    typedef logic signed [PROD_W-1:0] t_prod;

    // Saturate to the signed 24-bit range
    function automatic t_s24 sat24(input t_wide v);
        t_s24 res;
        if (v > S24_MAX) begin
            res = S24_MAX[STATE_W-1:0];
        end else if (v < S24_MIN) begin
            res = S24_MIN[STATE_W-1:0];
        end else begin
            res = v[STATE_W-1:0];
        end
        return res;
    endfunction

    // Floor of a product over 65536
    function automatic t_wide fl16(input t_prod p);
        t_prod q;
        q = p >>> 16;
        return t_wide'(q);
    endfunction

    // Floor of a product times one pixel over 65536
    function automatic t_wide fl16_one(input t_prod p);
        logic signed [SH_W-1:0] t;
        t = (SH_W'(p) <<< FRACTION_BITS) >>> 16;
        return t_wide'($signed(t[PROD_W-1:0]));
    endfunction

    // Configuration registers
    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [5:0]  r_radius;
    logic [11:0] r_gravity;
    logic [15:0] r_dt;
    logic [15:0] r_drag;
    logic [15:0] r_bounce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_FIELD_WIDTH;
            r_height  <= RST_FIELD_HEIGHT;
            r_radius  <= RST_BALL_RADIUS;
            r_gravity <= RST_GRAVITY;
            r_dt      <= RST_TIME_STEP;
            r_drag    <= RST_DRAG;
            r_bounce  <= RST_BOUNCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIELD_WIDTH:  r_width   <= i_cfg_data[11:0];
                CFG_FIELD_HEIGHT: r_height  <= i_cfg_data[11:0];
                CFG_BALL_RADIUS:  r_radius  <= i_cfg_data[5:0];
                CFG_GRAVITY:      r_gravity <= i_cfg_data[11:0];
                CFG_TIME_STEP:    r_dt      <= i_cfg_data;
                CFG_DRAG:         r_drag    <= i_cfg_data;
                CFG_BOUNCE:       r_bounce  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Geometry derived from the configuration
    t_wide             rad_w, wid_w, hgt_w;
    t_wide             hi_x, hi_y, floor_zone;
    logic signed [13:0] span_d;

    assign rad_w      = t_wide'({42'd0, r_radius}) <<< FRACTION_BITS;
    assign wid_w      = t_wide'({36'd0, r_width});
    assign hgt_w      = t_wide'({36'd0, r_height});
    assign hi_x       = (wid_w - t_wide'({42'd0, r_radius})) <<< FRACTION_BITS;
    assign hi_y       = (hgt_w - t_wide'({42'd0, r_radius})) <<< FRACTION_BITS;
    assign floor_zone = (hgt_w - t_wide'({41'd0, r_radius, 1'b0})) <<< FRACTION_BITS;
    assign span_d     = $signed({2'b00, r_width}) - $signed({7'd0, r_radius, 1'b0});

    // Ball table
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [31:0]        in_ball_ext;
    logic [31:0]        held_ball_ext;

    bpu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BALL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Working registers
    logic [IDX_W-1:0]  r_clr_addr, n_clr_addr;
    logic              r_cmd, n_cmd;
    logic [BALL_W-1:0] r_ball, n_ball;
    logic [RAND_W-1:0] r_rx, n_rx;
    logic [RAND_W-1:0] r_rvx, n_rvx;
    logic [RAND_W-1:0] r_rvy, n_rvy;
    logic              r_relaunch, n_relaunch;
    t_s24              r_x, n_x;
    t_s24              r_y, n_y;
    t_s24              r_vx, n_vx;
    t_s24              r_vy, n_vy;
    logic              r_bx, n_bx;
    logic              r_by, n_by;
    t_prod             r_prod, n_prod;
    logic              r_out_valid, n_out_valid;
    logic [BALL_W-1:0] r_out_id;
    logic [POS_W-1:0]  r_out_px;
    logic [POS_W-1:0]  r_out_py;
    logic              r_out_rel;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;

    t_s24  rd_px, rd_py, rd_vx, rd_vy;
    t_wide x_w, y_w, vy_w, rd_vy_w, rd_py_w;
    logic  rest;

    assign in_ball_ext   = 32'(i_ball);
    assign held_ball_ext = 32'(r_ball);
    assign rd_addr       = in_ball_ext[IDX_W-1:0];

    assign rd_px = $signed(rd_data[4*STATE_W-1:3*STATE_W]);
    assign rd_py = $signed(rd_data[3*STATE_W-1:2*STATE_W]);
    assign rd_vx = $signed(rd_data[2*STATE_W-1:STATE_W]);
    assign rd_vy = $signed(rd_data[STATE_W-1:0]);

    assign x_w     = t_wide'(r_x);
    assign y_w     = t_wide'(r_y);
    assign vy_w    = t_wide'(r_vy);
    assign rd_vy_w = t_wide'(rd_vy);
    assign rd_py_w = t_wide'(rd_py);

    // Ball resting near the floor
    assign rest = (rd_vy_w < ONE) && (rd_vy_w > -ONE) && (rd_py_w > floor_zone);

    // Table write port: clearing pass or write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = held_ball_ext[IDX_W-1:0];
        wr_data = {r_x, r_y, r_vx, r_vy};
        case (i_cmd.op)
            OP_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
            end
            OP_WRITE: wr_en = 1'b1;
            default: ;
        endcase
    end

    // Step sequencing of the shared multiplier and the ball registers
    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_ball      = r_ball;
        n_rx        = r_rx;
        n_rvx       = r_rvx;
        n_rvy       = r_rvy;
        n_relaunch  = r_relaunch;
        n_x         = r_x;
        n_y         = r_y;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_bx        = r_bx;
        n_by        = r_by;
        mul_a       = '0;
        mul_b       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (i_cmd.op)
            OP_CLEAR: n_clr_addr = r_clr_addr + 1'b1;
            OP_TAKE: begin
                n_cmd  = i_command;
                n_ball = i_ball;
                n_rx   = i_rand_x;
                n_rvx  = i_rand_vx;
                n_rvy  = i_rand_vy;
            end
            OP_LOAD: begin
                n_x        = rd_px;
                n_y        = rd_py;
                n_vx       = rd_vx;
                n_vy       = rd_vy;
                n_relaunch = (r_cmd == CMD_LAUNCH) || rest;
            end
            // launch: x across the free width, y on the top wall
            OP_L1: begin
                mul_a = MA_W'(span_d);
                mul_b = $signed({1'b0, r_rx});
            end
            OP_L2: begin
                n_x   = sat24(rad_w + fl16_one(r_prod));
                n_y   = sat24(rad_w);
                mul_a = MA_W'(LAUNCH_VX_SPAN);
                mul_b = $signed({1'b0, r_rvx});
            end
            OP_L3: begin
                n_vx  = sat24(fl16_one(r_prod) - VX_OFF);
                mul_a = MA_W'(LAUNCH_VY_SPAN);
                mul_b = $signed({1'b0, r_rvy});
            end
            OP_L4: n_vy = sat24(VY_BASE + fl16_one(r_prod));
            // drag
            OP_D1: begin
                mul_a = MA_W'(r_vx);
                mul_b = $signed({1'b0, r_drag});
            end
            OP_D2: begin
                n_vx  = sat24(fl16(r_prod));
                mul_a = MA_W'(r_vy);
                mul_b = $signed({1'b0, r_drag});
            end
            OP_D3: begin
                n_vy  = sat24(fl16(r_prod));
                mul_a = MA_W'(r_vx);
                mul_b = $signed({1'b0, r_dt});
            end
            // integration and gravity
            OP_I1: begin
                n_x   = sat24(x_w + fl16(r_prod));
                mul_a = MA_W'(r_vy);
                mul_b = $signed({1'b0, r_dt});
            end
            OP_I2: begin
                n_y   = sat24(y_w + fl16(r_prod));
                mul_a = $signed({13'd0, r_gravity});
                mul_b = $signed({1'b0, r_dt});
            end
            // walls, x and y interleaved so each bounce product is ready in time
            OP_XL: begin
                n_vy = sat24(vy_w + fl16_one(r_prod));
                n_bx = (x_w < rad_w);
                if (x_w < rad_w) n_x = sat24(rad_w);
                mul_a = -MA_W'(r_vx);
                mul_b = $signed({1'b0, r_bounce});
            end
            OP_YL: begin
                if (r_bx) n_vx = sat24(fl16(r_prod));
                n_by = (y_w < rad_w);
                if (y_w < rad_w) n_y = sat24(rad_w);
                mul_a = -MA_W'(r_vy);
                mul_b = $signed({1'b0, r_bounce});
            end
            OP_XH: begin
                if (r_by) n_vy = sat24(fl16(r_prod));
                n_bx = (x_w > hi_x);
                if (x_w > hi_x) n_x = sat24(hi_x);
                mul_a = -MA_W'(n_vx);
                mul_b = $signed({1'b0, r_bounce});
            end
            OP_YH: begin
                if (r_bx) n_vx = sat24(fl16(r_prod));
                n_by = (y_w > hi_y);
                if (y_w > hi_y) n_y = sat24(hi_y);
                mul_a = -MA_W'(r_vy);
                mul_b = $signed({1'b0, r_bounce});
            end
            OP_FIN: begin
                if (r_by) n_vy = sat24(fl16(r_prod));
            end
            OP_WRITE: n_out_valid = 1'b1;
            default: ;
        endcase
        n_prod = mul_a * mul_b;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ball     <= n_ball;
        r_rx       <= n_rx;
        r_rvx      <= n_rvx;
        r_rvy      <= n_rvy;
        r_relaunch <= n_relaunch;
        r_x        <= n_x;
        r_y        <= n_y;
        r_vx       <= n_vx;
        r_vy       <= n_vy;
        r_bx       <= n_bx;
        r_by       <= n_by;
        r_prod     <= n_prod;
        if (i_cmd.op == OP_WRITE) begin
            r_out_id  <= r_ball;
            r_out_px  <= r_x[POS_W-1:0];
            r_out_py  <= r_y[POS_W-1:0];
            r_out_rel <= r_relaunch;
        end
    end

    // Status back to the sequencer
    assign o_status.ball_ok    = (in_ball_ext < 32'(BALL_COUNT));
    assign o_status.relaunch   = (r_cmd == CMD_LAUNCH) || rest;
    assign o_status.launch_cmd = (r_cmd == CMD_LAUNCH);
    assign o_status.clr_last   = (r_clr_addr == IDX_W'(BALL_COUNT - 1));
    assign o_status.out_full   = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_ball_id    = r_out_id;
    assign o_pos_x      = r_out_px;
    assign o_pos_y      = r_out_py;
    assign o_relaunched = r_out_rel;

endmodule
